// ----- src/pcf_pkg.sv -----
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants for the pixel color filter.
// ----------------------------------------------------------------------------
package pcf_pkg;

  typedef logic [7:0] pix_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  typedef enum logic [1:0] {
    MODE_GRAY   = 2'd0,
    MODE_SEPIA  = 2'd1,
    MODE_INVERT = 2'd2,
    MODE_PASS   = 2'd3
  } filter_mode_t;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam pix_t PIX_MAX = 8'hFF;

  // sepia weights, unsigned q0.10
  localparam int   W_FRAC = 10;
  localparam logic [9:0] W_RR = 10'd402;
  localparam logic [9:0] W_RG = 10'd787;
  localparam logic [9:0] W_RB = 10'd194;
  localparam logic [9:0] W_GR = 10'd357;
  localparam logic [9:0] W_GG = 10'd702;
  localparam logic [9:0] W_GB = 10'd172;
  localparam logic [9:0] W_BR = 10'd279;
  localparam logic [9:0] W_BG = 10'd547;
  localparam logic [9:0] W_BB = 10'd134;

  // divide by 3 as multiply by 683 / 2048, exact for sums up to 765
  localparam logic [10:0] GRAY_RECIP = 11'd683;
  localparam int          GRAY_SHIFT = 11;

endpackage

// ----- src/pixel_color_filter_core.sv -----
// ----------------------------------------------------------------------------
// pixel_color_filter_core
// Per-pixel RGB filter: grayscale mean, sepia tone or color inversion.
// ----------------------------------------------------------------------------
// One pixel request is taken on every clock where start is high; busy is
// never raised. Each pixel comes out on a one-cycle out_valid strobe, in
// request order, after the input register and then the result register.
// The sustained rate is one pixel per clock. The receiver cannot stall,
// so out_valid pulses must be captured when seen. filter_mode lives at
// byte address 0 of the apb port (0 gray, 1 sepia, 2 invert, 3 pass
// through) and should be changed only while no pixel is in flight.
module pixel_color_filter_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel request
  input  logic                         start,
  output logic                         busy,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  // filtered pixel
  output logic                         out_valid,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcf_pkg::PADDR_W-1:0]  paddr,
  input  logic [pcf_pkg::PDATA_W-1:0]  pwdata,
  output logic [pcf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import pcf_pkg::*;

  filter_mode_t mode_r, mode_nxt;
  logic         cfg_wr;
  logic         cfg_hit;

  logic         in_valid_r;
  rgb_t         in_pix_r;
  filter_mode_t in_mode_r;

  rgb_t         math_pix;
  logic         out_valid_r;
  rgb_t         out_pix_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // register 0 occupies byte addresses 0 to 3
  assign cfg_hit = (paddr[PADDR_W-1] == 1'b0);
  assign cfg_wr  = psel & penable & pwrite & pready & cfg_hit;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr) begin
      mode_nxt = filter_mode_t'(pwdata[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GRAY;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign prdata = cfg_hit ? {{(PDATA_W-2){1'b0}}, mode_r} : '0;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    in_pix_r  <= '{red: in_red, green: in_green, blue: in_blue};
    in_mode_r <= mode_r;
  end

  pcf_pixel_math u_math (
    .mode    (in_mode_r),
    .pix_in  (in_pix_r),
    .pix_out (math_pix)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r <= math_pix;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_pix_r.red;
  assign out_green = out_pix_r.green;
  assign out_blue  = out_pix_r.blue;

endmodule

// ----- src/pcf_pixel_math.sv -----
// ----------------------------------------------------------------------------
// pcf_pixel_math
// Combinational color transform: gray mean, sepia, inversion or pass.
// ----------------------------------------------------------------------------
module pcf_pixel_math (
  input  pcf_pkg::filter_mode_t mode,
  input  pcf_pkg::rgb_t         pix_in,
  output pcf_pkg::rgb_t         pix_out
);
  import pcf_pkg::*;

  function automatic pix_t sepia_ch(input logic [9:0] wr, input logic [9:0] wg,
                                    input logic [9:0] wb, input rgb_t p);
    logic [20:0] acc;
    acc = 21'(wr) * 21'(p.red) + 21'(wg) * 21'(p.green) + 21'(wb) * 21'(p.blue);
    // saturate anything at or above 256.0
    if (|acc[20:W_FRAC+8]) begin
      return PIX_MAX;
    end
    return acc[W_FRAC+7:W_FRAC];
  endfunction

  logic [9:0]  gray_sum;
  logic [20:0] gray_prod;
  pix_t        gray_mean;

  assign gray_sum  = 10'(pix_in.red) + 10'(pix_in.green) + 10'(pix_in.blue);
  assign gray_prod = 21'(gray_sum) * 21'(GRAY_RECIP);
  assign gray_mean = gray_prod[GRAY_SHIFT+7:GRAY_SHIFT];

  always_comb begin
    unique case (mode)
      MODE_GRAY: begin
        pix_out = '{red: gray_mean, green: gray_mean, blue: gray_mean};
      end
      MODE_SEPIA: begin
        pix_out.red   = sepia_ch(W_RR, W_RG, W_RB, pix_in);
        pix_out.green = sepia_ch(W_GR, W_GG, W_GB, pix_in);
        pix_out.blue  = sepia_ch(W_BR, W_BG, W_BB, pix_in);
      end
      MODE_INVERT: begin
        pix_out.red   = PIX_MAX - pix_in.red;
        pix_out.green = PIX_MAX - pix_in.green;
        pix_out.blue  = PIX_MAX - pix_in.blue;
      end
      default: begin
        pix_out = pix_in;
      end
    endcase
  end

endmodule

// ----- src/pcf_checker.sv -----
// ----------------------------------------------------------------------------
// pcf_checker
// Port-level checks for the pixel color filter, bound to the top level.
// ----------------------------------------------------------------------------
module pcf_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic pready
);

  // every taken request yields a result through the input and result registers
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("request without result");

  // no result without a taken request that passed the input and result registers
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without request");

  // the filter never holds off requests or register accesses
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (!busy && pready))
    else $error("stall signaled");

endmodule

bind pixel_color_filter_core pcf_checker u_pcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .pready    (pready)
);
